// ===== rtl/cgir_pkg.sv =====
// Shared types and constants for the composite glyph index remapper.
// Holds the parser phase type, the status codes and the request record passed
// from the parser to the output stage. No dependencies.
package cgir_pkg;

  localparam int MapDepthDef = 65536;

  localparam logic [15:0] FLG_WORDS      = 16'h0001;
  localparam logic [15:0] FLG_SCALE      = 16'h0008;
  localparam logic [15:0] FLG_MORE       = 16'h0020;
  localparam logic [15:0] FLG_XY_SCALE   = 16'h0040;
  localparam logic [15:0] FLG_TWO_BY_TWO = 16'h0080;
  localparam logic [15:0] FLG_INSTR      = 16'h0100;

  localparam logic [15:0] HEADER_LEN = 16'd10;
  localparam logic [15:0] NOT_KEPT   = 16'hFFFF;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_REF   = 2'd1;
  localparam logic [1:0] ST_TRUNC_CMP = 2'd2;
  localparam logic [1:0] ST_TRUNC_INS = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_PASS   = 3'd1,
    PH_COMP   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_ILEN   = 3'd4,
    PH_IBODY  = 3'd5
  } phase_e;

  // One emitting request: a single byte, or a glyph index pair to remap
  typedef struct packed {
    logic       pair;
    logic [7:0] byte_hi;
    logic [7:0] byte_lo;
    logic       last;
    logic       bad;
    logic [1:0] trunc;
  } event_t;

endpackage

// ===== rtl/composite_glyph_index_remap.sv =====
// Top level of the composite glyph index remapper: parser, remap table memory
// and output stage. Depends on cgir_pkg, cgir_parser, cgir_remap_mem, cgir_out_stage.
//
// Channel   Dir  Handshake         Payload
// s_axis    in   tvalid/tready     tdata {data_byte, map_value, map_index}, tlast, tuser=action
// m_axis    out  tvalid/tready     tdata out_byte, tlast out_last, tuser status
// cfg       in   cfg_we_i          cfg_wdata_i = map_size
//
// One request per cycle while the output is ready; each request is registered
// in an output slot before its bytes leave. The high byte of a glyph index yields
// nothing unless it ends the record; the low byte reads the table in its acceptance
// cycle and yields two result bytes. A second request slot in the output stage
// absorbs the extra byte, so input stalls only when both slots are full and the
// output is not taking a final byte. Reset clears parser, status and output slots;
// table contents stay undefined until loaded.
module composite_glyph_index_remap #(
  parameter int MAP_DEPTH = cgir_pkg::MapDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // map_index[15:0], map_value[31:16], data_byte[39:32]
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tuser_i,  // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte[7:0]
  output logic        m_axis_tlast_o,
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  localparam int          AW       = $clog2(MAP_DEPTH);
  localparam logic [16:0] DepthLim = 17'(MAP_DEPTH);

  logic             acc;
  logic             byte_acc;
  logic             load_we;
  logic             ev_valid;
  cgir_pkg::event_t ev;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [15:0]      rdata;
  logic             free;

  assign s_axis_tready_o = free;
  assign acc      = s_axis_tvalid_i && free;
  assign byte_acc = acc && s_axis_tuser_i;
  // drop loads beyond the table
  assign load_we  = acc && !s_axis_tuser_i && ({1'b0, s_axis_tdata_i[15:0]} < DepthLim);

  cgir_parser #(
    .MAP_DEPTH (MAP_DEPTH),
    .AW        (AW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_acc_i  (byte_acc),
    .data_byte_i (s_axis_tdata_i[39:32]),
    .last_i      (s_axis_tlast_i),
    .ev_valid_o  (ev_valid),
    .ev_o        (ev),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr)
  );

  cgir_remap_mem #(
    .MAP_DEPTH (MAP_DEPTH),
    .AW        (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (s_axis_tdata_i[AW-1:0]),
    .wdata_i (s_axis_tdata_i[31:16]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  cgir_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (byte_acc && ev_valid),
    .ev_i            (ev),
    .rdata_i         (rdata),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== rtl/cgir_remap_mem.sv =====
// Remap table: source glyph index to subset index, one write and one read
// port, registered read data. Depends on nothing outside itself.
module cgir_remap_mem #(
  parameter int MAP_DEPTH = 65536,
  parameter int AW        = $clog2(MAP_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem_q [MAP_DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cgir_parser.sv =====
// Glyph record parser: walks header, components and instructions byte by
// byte, issues the table read for each glyph index. Uses cgir_pkg.
module cgir_parser #(
  parameter int MAP_DEPTH = cgir_pkg::MapDepthDef,
  parameter int AW        = $clog2(MAP_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             byte_acc_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_i,
  output logic             ev_valid_o,
  output cgir_pkg::event_t ev_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o
);

  localparam logic [16:0] DepthLim = 17'(MAP_DEPTH);

  cgir_pkg::phase_e phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] flags_q, flags_d;
  logic [3:0]  skip_q, skip_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] ilen_q, ilen_d;
  logic [15:0] map_size_q;
  logic [15:0] src;
  logic [15:0] ilen_new;
  logic [3:0]  skip_dec;
  logic        src_bad;

  function automatic logic [3:0] operand_bytes(input logic [15:0] f);
    logic [3:0] n;
    n = ((f & cgir_pkg::FLG_WORDS) != 16'd0) ? 4'd4 : 4'd2;
    if ((f & cgir_pkg::FLG_SCALE) != 16'd0) begin
      n = n + 4'd2;
    end else if ((f & cgir_pkg::FLG_XY_SCALE) != 16'd0) begin
      n = n + 4'd4;
    end else if ((f & cgir_pkg::FLG_TWO_BY_TWO) != 16'd0) begin
      n = n + 4'd8;
    end
    return n;
  endfunction

  function automatic cgir_pkg::phase_e after_component(input logic [15:0] f);
    if ((f & cgir_pkg::FLG_MORE) != 16'd0) begin
      return cgir_pkg::PH_COMP;
    end else if ((f & cgir_pkg::FLG_INSTR) != 16'd0) begin
      return cgir_pkg::PH_ILEN;
    end
    return cgir_pkg::PH_PASS;
  endfunction

  assign src      = {held_q, data_byte_i};
  assign src_bad  = (src >= map_size_q) || ({1'b0, src} >= DepthLim);
  assign ilen_new = {ilen_q[15:8], data_byte_i};
  assign skip_dec = (skip_q != 4'd0) ? skip_q - 4'd1 : 4'd0;
  assign rd_addr_o = src[AW-1:0];

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    skip_d  = skip_q;
    held_d  = held_q;
    ilen_d  = ilen_q;
    ev_o         = '0;
    ev_o.byte_hi = held_q;
    ev_o.byte_lo = data_byte_i;
    ev_o.last    = last_i;
    ev_o.bad     = src_bad;
    ev_valid_o   = 1'b1;
    rd_en_o      = 1'b0;

    unique case (phase_q)
      cgir_pkg::PH_HEADER: begin
        if (pos_q == 16'd0) begin
          held_d = data_byte_i;
        end
        if (pos_q == cgir_pkg::HEADER_LEN - 16'd1) begin
          skip_d  = 4'd0;
          phase_d = held_q[7] ? cgir_pkg::PH_COMP : cgir_pkg::PH_PASS;
        end
      end
      cgir_pkg::PH_COMP: begin
        case (skip_q)
          4'd0: begin
            flags_d = {data_byte_i, 8'd0};
            skip_d  = 4'd1;
          end
          4'd1: begin
            flags_d = {flags_q[15:8], data_byte_i};
            skip_d  = 4'd2;
          end
          4'd2: begin
            // hold the index high byte until its low byte arrives
            held_d     = data_byte_i;
            ev_o.byte_lo = data_byte_i;
            ev_valid_o = last_i;
            skip_d     = 4'd3;
          end
          default: begin
            ev_o.pair = 1'b1;
            rd_en_o   = byte_acc_i;
            skip_d    = operand_bytes(flags_q);
            phase_d   = cgir_pkg::PH_SKIP;
          end
        endcase
      end
      cgir_pkg::PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 4'd0) begin
          phase_d = after_component(flags_q);
        end
      end
      cgir_pkg::PH_ILEN: begin
        if (skip_q == 4'd0) begin
          ilen_d = {data_byte_i, 8'd0};
          skip_d = 4'd1;
        end else begin
          ilen_d  = ilen_new;
          skip_d  = 4'd0;
          phase_d = (ilen_new != 16'd0) ? cgir_pkg::PH_IBODY : cgir_pkg::PH_PASS;
        end
      end
      cgir_pkg::PH_IBODY: begin
        if (ilen_q != 16'd0) begin
          ilen_d = ilen_q - 16'd1;
        end
        if (ilen_d == 16'd0) begin
          phase_d = cgir_pkg::PH_PASS;
        end
      end
      default: begin
      end
    endcase

    if (pos_q != 16'hFFFF) begin
      pos_d = pos_q + 16'd1;
    end

    if (last_i) begin
      if (phase_d == cgir_pkg::PH_COMP || phase_d == cgir_pkg::PH_SKIP) begin
        ev_o.trunc = cgir_pkg::ST_TRUNC_CMP;
      end else if (phase_d == cgir_pkg::PH_ILEN || phase_d == cgir_pkg::PH_IBODY) begin
        ev_o.trunc = cgir_pkg::ST_TRUNC_INS;
      end
      phase_d = cgir_pkg::PH_HEADER;
      pos_d   = 16'd0;
      flags_d = 16'd0;
      skip_d  = 4'd0;
      held_d  = 8'd0;
      ilen_d  = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cgir_pkg::PH_HEADER;
      pos_q   <= 16'd0;
      flags_q <= 16'd0;
      skip_q  <= 4'd0;
      held_q  <= 8'd0;
      ilen_q  <= 16'd0;
    end else if (byte_acc_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      flags_q <= flags_d;
      skip_q  <= skip_d;
      held_q  <= held_d;
      ilen_q  <= ilen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_q <= 16'd1;
    end else if (cfg_we_i) begin
      map_size_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== rtl/cgir_out_stage.sv =====
// Output stage: holds up to two requests, merges the table read data, keeps
// the sticky status and emits one or two result bytes per request. Uses cgir_pkg.
module cgir_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cgir_pkg::event_t ev_i,
  input  logic [15:0]      rdata_i,
  output logic             free_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  output logic [1:0]       m_axis_tuser_o
);

  cgir_pkg::event_t head_q;
  cgir_pkg::event_t tail_q;
  logic             head_vld_q;
  logic             tail_vld_q;
  logic             sub_q;
  logic [1:0]       err_q;
  logic [1:0]       err_bad;
  logic [1:0]       err_new;
  logic             bad_eff;
  logic             final_beat;
  logic             beat_done;
  logic             pop;

  // The table read data stays valid while the index pair waits: the next read
  // needs at least four further requests, more than the two slots can hold.
  assign bad_eff    = head_q.pair && (head_q.bad || rdata_i == cgir_pkg::NOT_KEPT);
  assign err_bad    = (err_q == cgir_pkg::ST_OK && bad_eff) ? cgir_pkg::ST_BAD_REF : err_q;
  assign err_new    = (err_bad == cgir_pkg::ST_OK) ? head_q.trunc : err_bad;
  assign final_beat = !head_q.pair || sub_q;
  assign beat_done  = head_vld_q && m_axis_tready_i;
  assign pop        = beat_done && final_beat;
  assign free_o     = !tail_vld_q || pop;

  always_comb begin
    if (!head_q.pair) begin
      m_axis_tdata_o = head_q.byte_lo;
    end else if (bad_eff) begin
      m_axis_tdata_o = sub_q ? head_q.byte_lo : head_q.byte_hi;
    end else begin
      m_axis_tdata_o = sub_q ? rdata_i[7:0] : rdata_i[15:8];
    end
  end

  assign m_axis_tvalid_o = head_vld_q;
  assign m_axis_tlast_o  = head_q.last && final_beat;
  assign m_axis_tuser_o  = err_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
      sub_q      <= 1'b0;
      err_q      <= cgir_pkg::ST_OK;
    end else begin
      if (pop) begin
        // advance the tail, or the new request, into the head
        head_vld_q <= tail_vld_q || load_i;
        tail_vld_q <= tail_vld_q && load_i;
        sub_q      <= 1'b0;
        err_q      <= err_new;
      end else begin
        if (load_i) begin
          head_vld_q <= 1'b1;
          tail_vld_q <= head_vld_q;
        end
        if (beat_done) begin
          sub_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      head_q <= tail_vld_q ? tail_q : ev_i;
    end else if (load_i && !head_vld_q) begin
      head_q <= ev_i;
    end
    if (load_i && (pop ? tail_vld_q : head_vld_q)) begin
      tail_q <= ev_i;
    end
  end

endmodule

// ===== bench/tb_composite_glyph_index_remap.sv =====
// Testbench for composite_glyph_index_remap: streams remap-table loads and glyph
// records through the block and checks every output byte, last flag and status
// against an in-bench predictor. Depends on cgir_pkg and the RTL top level.
module tb_composite_glyph_index_remap;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } out_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;  // map_index[15:0], map_value[31:16], data_byte[39:32]
  logic        s_axis_tlast_i;
  logic        s_axis_tuser_i;  // action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;  // out_byte[7:0]
  logic        m_axis_tlast_o;
  logic [1:0]  m_axis_tuser_o;  // status[1:0]

  composite_glyph_index_remap uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Predictor state
  logic [15:0]      remap_tbl [0:65535];
  bit               tbl_loaded [0:65535];
  logic [15:0]      map_sz;
  logic [15:0]      rec_pos;
  cgir_pkg::phase_e cur_phase;
  logic [15:0]      comp_flags;
  logic [3:0]       skip_left;
  logic [7:0]       held_byte;
  logic [15:0]      instr_left;
  logic [1:0]       sticky_status;

  out_beat_t   remapped_q [$];
  logic [7:0]  rec_q [$];

  int          items_sent;
  int          results_seen;
  int          records_sent;
  int          indices_remapped;
  int          error_count;
  bit [3:0]    status_seen;
  bit          steady;
  int          rx_hold_len;
  int          stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] operand_len(input logic [15:0] f);
    logic [3:0] n;
    n = ((f & cgir_pkg::FLG_WORDS) != 0) ? 4'd4 : 4'd2;
    if ((f & cgir_pkg::FLG_SCALE) != 0) n += 4'd2;
    else if ((f & cgir_pkg::FLG_XY_SCALE) != 0) n += 4'd4;
    else if ((f & cgir_pkg::FLG_TWO_BY_TWO) != 0) n += 4'd8;
    return n;
  endfunction

  function automatic void note_error(input logic [1:0] code);
    if (sticky_status == cgir_pkg::ST_OK) sticky_status = code;
  endfunction

  // Advance the predictor by one accepted request and queue the bytes it yields
  task automatic remap_step(input logic act, input logic [15:0] idx, input logic [15:0] val,
                            input logic [7:0] b, input logic lst);
    logic [7:0] obytes [2];
    int         n;
    logic [15:0] src;
    out_beat_t  beat;
    n = 0;
    if (!act) begin
      remap_tbl[idx] = val;
      tbl_loaded[idx] = 1'b1;
    end else begin
      case (cur_phase)
        cgir_pkg::PH_HEADER: begin
          if (rec_pos == 16'd0) held_byte = b;
          obytes[n] = b;
          n++;
          if (rec_pos == cgir_pkg::HEADER_LEN - 16'd1) begin
            skip_left = 4'd0;
            cur_phase = held_byte[7] ? cgir_pkg::PH_COMP : cgir_pkg::PH_PASS;
          end
        end
        cgir_pkg::PH_COMP: begin
          if (skip_left == 4'd0) begin
            comp_flags = {b, 8'h00};
            obytes[n] = b;
            n++;
            skip_left = 4'd1;
          end else if (skip_left == 4'd1) begin
            comp_flags[7:0] = b;
            obytes[n] = b;
            n++;
            skip_left = 4'd2;
          end else if (skip_left == 4'd2) begin
            held_byte = b;
            if (lst) begin
              obytes[n] = b;
              n++;
            end
            skip_left = 4'd3;
          end else begin
            src = {held_byte, b};
            indices_remapped++;
            if (src < map_sz && remap_tbl[src] != cgir_pkg::NOT_KEPT) begin
              obytes[0] = remap_tbl[src][15:8];
              obytes[1] = remap_tbl[src][7:0];
            end else begin
              note_error(cgir_pkg::ST_BAD_REF);
              obytes[0] = held_byte;
              obytes[1] = b;
            end
            n = 2;
            skip_left = operand_len(comp_flags);
            cur_phase = cgir_pkg::PH_SKIP;
          end
        end
        cgir_pkg::PH_SKIP: begin
          obytes[n] = b;
          n++;
          if (skip_left != 4'd0) skip_left--;
          if (skip_left == 4'd0) begin
            if ((comp_flags & cgir_pkg::FLG_MORE) != 0) cur_phase = cgir_pkg::PH_COMP;
            else if ((comp_flags & cgir_pkg::FLG_INSTR) != 0) cur_phase = cgir_pkg::PH_ILEN;
            else cur_phase = cgir_pkg::PH_PASS;
          end
        end
        cgir_pkg::PH_ILEN: begin
          obytes[n] = b;
          n++;
          if (skip_left == 4'd0) begin
            instr_left = {b, 8'h00};
            skip_left = 4'd1;
          end else begin
            instr_left[7:0] = b;
            skip_left = 4'd0;
            cur_phase = (instr_left != 16'd0) ? cgir_pkg::PH_IBODY : cgir_pkg::PH_PASS;
          end
        end
        cgir_pkg::PH_IBODY: begin
          obytes[n] = b;
          n++;
          if (instr_left != 16'd0) instr_left--;
          if (instr_left == 16'd0) cur_phase = cgir_pkg::PH_PASS;
        end
        default: begin
          obytes[n] = b;
          n++;
        end
      endcase
      if (rec_pos != 16'hFFFF) rec_pos++;
      if (lst) begin
        if (cur_phase == cgir_pkg::PH_COMP || cur_phase == cgir_pkg::PH_SKIP)
          note_error(cgir_pkg::ST_TRUNC_CMP);
        else if (cur_phase == cgir_pkg::PH_ILEN || cur_phase == cgir_pkg::PH_IBODY)
          note_error(cgir_pkg::ST_TRUNC_INS);
        rec_pos = 16'd0;
        cur_phase = cgir_pkg::PH_HEADER;
        comp_flags = 16'd0;
        skip_left = 4'd0;
        held_byte = 8'd0;
        instr_left = 16'd0;
      end
      for (int k = 0; k < n; k++) begin
        beat.data = obytes[k];
        beat.last = lst && (k == n - 1);
        beat.status = sticky_status;
        remapped_q.insert(remapped_q.size(), beat);
      end
    end
  endtask

  // Offer one request, idling at random first, and predict it once accepted
  task automatic drive_req(input logic act, input logic [15:0] idx, input logic [15:0] val,
                           input logic [7:0] b, input logic lst);
    while (!steady && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {b, val, idx};
    s_axis_tlast_i  <= lst;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    remap_step(act, idx, val, b, lst);
  endtask

  // Load any in-range entry a glyph index is about to read but nobody has written yet
  task automatic send_req(input logic act, input logic [15:0] idx, input logic [15:0] val,
                          input logic [7:0] b, input logic lst);
    logic [15:0] src;
    src = {held_byte, b};
    if (act && cur_phase == cgir_pkg::PH_COMP && skip_left == 4'd3 && src < map_sz &&
        !tbl_loaded[src])
      drive_req(1'b0, src, ($urandom_range(0, 9) == 0) ? cgir_pkg::NOT_KEPT : 16'($urandom),
                8'($urandom), 1'($urandom));
    drive_req(act, idx, val, b, lst);
  endtask

  task automatic rec_add(input logic [7:0] b);
    rec_q.insert(rec_q.size(), b);
  endtask

  task automatic send_record();
    for (int i = 0; i < rec_q.size(); i++)
      send_req(1'b1, 16'($urandom), 16'($urandom), rec_q[i], i == rec_q.size() - 1);
    records_sent++;
  endtask

  task automatic start_record(input logic [7:0] first);
    rec_q.delete();
    rec_add(first);
    repeat (9) rec_add(8'($urandom));
  endtask

  task automatic add_component(input logic [15:0] flags, input logic [15:0] gid);
    rec_add(flags[15:8]);
    rec_add(flags[7:0]);
    rec_add(gid[15:8]);
    rec_add(gid[7:0]);
    repeat (operand_len(flags)) rec_add(8'($urandom));
  endtask

  task automatic add_instr(input logic [15:0] len);
    rec_add(len[15:8]);
    rec_add(len[7:0]);
    repeat (len) rec_add(8'($urandom));
  endtask

  task automatic cut_record(input int len);
    while (rec_q.size() > len) void'(rec_q.pop_back());
  endtask

  // Wait for the block to go quiet, then write map_size
  task automatic configure(input logic [15:0] size);
    s_axis_tvalid_i <= 1'b0;
    while (remapped_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    map_sz = size;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_glyph();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, map_sz - 1));
    if (r < 85) return (r & 1) ? map_sz : map_sz - 16'd1;
    return 16'($urandom);
  endfunction

  task automatic build_composite(input int ncomp);
    logic [15:0] flags;
    start_record(8'h80 | 8'($urandom_range(0, 127)));
    for (int c = 0; c < ncomp; c++) begin
      flags = 16'($urandom);
      if (c == ncomp - 1) flags &= ~cgir_pkg::FLG_MORE;
      else flags |= cgir_pkg::FLG_MORE;
      add_component(flags, pick_glyph());
    end
    if ((flags & cgir_pkg::FLG_INSTR) != 0)
      add_instr(($urandom_range(0, 49) == 0) ? 16'($urandom_range(256, 300))
                                               : 16'($urandom_range(0, 8)));
    repeat ($urandom_range(0, 3)) rec_add(8'($urandom));
  endtask

  task automatic test_loads();
    configure(16'd64);
    send_req(1'b0, 16'd0, 16'h0000, 8'h00, 1'b0);
    send_req(1'b0, 16'd63, 16'h00FF, 8'hFF, 1'b1);
    send_req(1'b0, 16'd5, cgir_pkg::NOT_KEPT, 8'h5A, 1'b0);
    send_req(1'b0, 16'hFFFF, 16'hABCD, 8'hA5, 1'b1);
    send_req(1'b0, 16'hFFFE, 16'h1234, 8'h00, 1'b0);
    send_req(1'b0, 16'h8000, 16'h7FFF, 8'h80, 1'b0);
  endtask

  task automatic test_passthrough();
    start_record(8'h00);
    repeat (4) rec_add(8'($urandom));
    send_record();
    rec_q = '{8'hFF, 8'hFF, 8'h00, 8'h01};
    send_record();
    rec_q = '{8'h80};
    send_record();
    start_record(8'h7F);
    send_record();
  endtask

  task automatic test_component_forms();
    start_record(8'hFF);
    add_component(cgir_pkg::FLG_MORE | cgir_pkg::FLG_WORDS, 16'd0);
    add_component(cgir_pkg::FLG_MORE | cgir_pkg::FLG_SCALE, 16'd63);
    add_component(cgir_pkg::FLG_MORE | cgir_pkg::FLG_XY_SCALE | cgir_pkg::FLG_WORDS, 16'd1);
    add_component(cgir_pkg::FLG_MORE | cgir_pkg::FLG_TWO_BY_TWO, 16'd2);
    add_component(cgir_pkg::FLG_INSTR, 16'd63);
    add_instr(16'd3);
    repeat (2) rec_add(8'($urandom));
    send_record();
    // zero-length instructions end the record cleanly
    start_record(8'h80);
    add_component(cgir_pkg::FLG_INSTR | cgir_pkg::FLG_WORDS, 16'd0);
    add_instr(16'd0);
    send_record();
    start_record(8'hC0);
    add_component(16'h0000, 16'd7);
    send_record();
  endtask

  task automatic test_map_size_max();
    configure(16'hFFFF);
    start_record(8'hFF);
    add_component(16'hFFFF, 16'hFFFE);
    add_component(16'h0000, 16'd0);
    send_record();
  endtask

  task automatic test_bad_reference();
    configure(16'hFFFF);
    start_record(8'hFF);
    add_component(cgir_pkg::FLG_MORE, 16'hFFFF);
    add_component(cgir_pkg::FLG_MORE, 16'd5);
    add_component(16'h0000, 16'd0);
    send_record();
    configure(16'd1);
    start_record(8'h80);
    add_component(cgir_pkg::FLG_MORE, 16'd0);
    add_component(16'h0000, 16'd1);
    send_record();
  endtask

  task automatic test_truncated_component();
    start_record(8'h80);
    send_record();
    // end on the high byte of the glyph index: it goes out unchanged
    start_record(8'h81);
    add_component(16'h0000, 16'd0);
    cut_record(13);
    send_record();
    start_record(8'h90);
    add_component(cgir_pkg::FLG_WORDS, 16'd0);
    cut_record(16);
    send_record();
    start_record(8'hA0);
    add_component(cgir_pkg::FLG_MORE, 16'd0);
    send_record();
  endtask

  task automatic test_truncated_instructions();
    start_record(8'h80);
    add_component(cgir_pkg::FLG_INSTR, 16'd0);
    add_instr(16'd5);
    cut_record(17);
    send_record();
    start_record(8'hF0);
    add_component(cgir_pkg::FLG_INSTR, 16'd0);
    add_instr(16'd5);
    cut_record(rec_q.size() - 2);
    send_record();
  endtask

  task automatic test_backpressure();
    rx_hold_len = 400;
    repeat (3) begin
      build_composite($urandom_range(2, 4));
      send_record();
    end
  endtask

  task automatic test_random_stream(input logic [15:0] size, input int n, input bit calm);
    int target;
    int kind;
    configure(size);
    steady = calm;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0)
        send_req(1'b0, ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, map_sz - 1))
                                                   : 16'($urandom),
                 16'($urandom), 8'($urandom), 1'($urandom));
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        build_composite($urandom_range(1, 4));
      end else if (kind < 80) begin
        start_record(8'($urandom_range(0, 127)));
        repeat ($urandom_range(0, 12)) rec_add(8'($urandom));
        if ($urandom_range(0, 3) == 0) cut_record($urandom_range(1, 9));
      end else if (kind < 90) begin
        build_composite($urandom_range(1, 3));
        cut_record($urandom_range(1, rec_q.size() - 1));
      end else begin
        rec_q.delete();
        repeat ($urandom_range(1, 40)) rec_add(8'($urandom));
      end
      send_record();
    end
    steady = 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len > 0) begin
        hold_left = rx_hold_len;
        rx_hold_len = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      status_seen[m_axis_tuser_o] = 1'b1;
      if (remapped_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result: byte %h last %b status %0d", $time,
                   m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      end else begin
        want = remapped_q.pop_front();
        if (m_axis_tdata_o !== want.data || m_axis_tlast_o !== want.last ||
            m_axis_tuser_o !== want.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch: expected byte %h last %b status %0d, got %h %b %0d",
                     $time, want.data, want.last, want.status,
                     m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, remapped_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int first_err;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 16'd0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 40'd0;
    s_axis_tlast_i  <= 1'b0;
    s_axis_tuser_i  <= 1'b0;
    map_sz        = 16'd1;
    rec_pos       = 16'd0;
    cur_phase     = cgir_pkg::PH_HEADER;
    comp_flags    = 16'd0;
    skip_left     = 4'd0;
    held_byte     = 8'd0;
    instr_left    = 16'd0;
    sticky_status = cgir_pkg::ST_OK;
    items_sent = 0;
    results_seen = 0;
    records_sent = 0;
    indices_remapped = 0;
    error_count = 0;
    status_seen = '0;
    steady = 1'b0;
    rx_hold_len = 0;
    stall_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_loads();
    test_passthrough();
    test_component_forms();
    test_map_size_max();
    // rotate which error lands first, since the status holds the first one
    first_err = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      case ((first_err + k) % 3)
        0:       test_bad_reference();
        1:       test_truncated_component();
        default: test_truncated_instructions();
      endcase
    end
    test_backpressure();
    test_random_stream(16'd1, 100, 1'b0);
    test_random_stream(16'hFFFF, 150, 1'b1);
    test_random_stream(16'($urandom_range(2, 65534)), 150, 1'b0);
    test_random_stream(16'd200, 150, 1'b0);

    s_axis_tvalid_i <= 1'b0;
    while (remapped_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d requests in %0d records, %0d glyph indices looked up; %0d bytes out.",
             items_sent, records_sent, indices_remapped, results_seen);
    $display("Status values seen (bit per code): %b, mismatches: %0d", status_seen,
             error_count);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cgir_pkg.sv
rtl/cgir_remap_mem.sv
rtl/cgir_parser.sv
rtl/cgir_out_stage.sv
rtl/composite_glyph_index_remap.sv
bench/tb_composite_glyph_index_remap.sv
